// ===== rtl/core/bchc_pkg.sv =====
// ----------------------------------------------------------------------------
// bchc_pkg
// Shared types and constants for the button click/hold classifier.
// ----------------------------------------------------------------------------
package bchc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned S_DATA_W = 40;  // 33 payload bits padded to bytes
    localparam int unsigned M_DATA_W = 16;  // 9 flag bits padded to bytes

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = CFG_W'(20);
    localparam logic [CFG_W-1:0] DBL_GAP_RST   = CFG_W'(250);
    localparam logic [CFG_W-1:0] HOLD_RST      = CFG_W'(1000);
    localparam logic [CFG_W-1:0] LONG_HOLD_RST = CFG_W'(3000);

    typedef enum logic [CFG_AW-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_DBL_GAP   = 2'd1,
        REG_HOLD      = 2'd2,
        REG_LONG_HOLD = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] double_click_gap_ms;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] long_hold_ms;
    } cfg_t;

    // Result flags, last field in the lowest bit when packed into tdata.
    typedef struct packed {
        logic is_holding_long;
        logic is_holding;
        logic is_down;
        logic long_hold_event;
        logic hold_event;
        logic double_click_event;
        logic click_event;
        logic release_event;
        logic press_event;
    } res_t;

    typedef struct packed {
        logic              last_level;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] release_time;
        logic              skip_release;
        logic              single_allowed;
        logic              hold_done;
        logic              long_hold_done;
        logic              double_on_release;
        logic              awaiting_second;
        logic              double_done;
        logic              holding_flag;
        logic              holding_long_flag;
    } st_t;

    // button released, times and flags clear
    localparam st_t ST_RST = '{
        last_level:        1'b1,
        press_time:        '0,
        release_time:      '0,
        skip_release:      1'b0,
        single_allowed:    1'b0,
        hold_done:         1'b0,
        long_hold_done:    1'b0,
        double_on_release: 1'b0,
        awaiting_second:   1'b0,
        double_done:       1'b0,
        holding_flag:      1'b0,
        holding_long_flag: 1'b0
    };

endpackage

// ===== rtl/core/bchc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bchc_cfg_regs
// Threshold registers, written through the plain write port.
// ----------------------------------------------------------------------------
module bchc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bchc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [bchc_pkg::CFG_W-1:0]    cfg_wdata,
    output bchc_pkg::cfg_t                cfg
);

    bchc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms         <= bchc_pkg::DEBOUNCE_RST;
            cfg_reg.double_click_gap_ms <= bchc_pkg::DBL_GAP_RST;
            cfg_reg.hold_ms             <= bchc_pkg::HOLD_RST;
            cfg_reg.long_hold_ms        <= bchc_pkg::LONG_HOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (bchc_pkg::cfg_idx_t'(cfg_addr))
                bchc_pkg::REG_DEBOUNCE:  cfg_reg.debounce_ms         <= cfg_wdata;
                bchc_pkg::REG_DBL_GAP:   cfg_reg.double_click_gap_ms <= cfg_wdata;
                bchc_pkg::REG_HOLD:      cfg_reg.hold_ms             <= cfg_wdata;
                bchc_pkg::REG_LONG_HOLD: cfg_reg.long_hold_ms        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bchc_core.sv =====
// ----------------------------------------------------------------------------
// bchc_core
// Button state register and the per-sample classification step.
// ----------------------------------------------------------------------------
module bchc_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic                          level,
    input  logic [bchc_pkg::TIME_W-1:0]   now,
    input  bchc_pkg::cfg_t                cfg,
    output bchc_pkg::res_t                res
);

    bchc_pkg::st_t st_reg;
    bchc_pkg::st_t st_next;

    logic [bchc_pkg::TIME_W-1:0] d_rel;
    logic [bchc_pkg::TIME_W-1:0] d_prs;
    logic [bchc_pkg::TIME_W-1:0] d_rel_new;
    logic [bchc_pkg::TIME_W-1:0] d_prs_new;
    logic [bchc_pkg::TIME_W-1:0] debounce;
    logic [bchc_pkg::TIME_W-1:0] gap;
    logic [bchc_pkg::TIME_W-1:0] gap_x2;
    logic                        press_ok;
    logic                        release_ok;
    logic                        second_press;

    assign debounce = bchc_pkg::TIME_W'(cfg.debounce_ms);
    assign gap      = bchc_pkg::TIME_W'(cfg.double_click_gap_ms);
    assign gap_x2   = {gap[bchc_pkg::TIME_W-2:0], 1'b0};

    assign d_rel = now - st_reg.release_time;
    assign d_prs = now - st_reg.press_time;

    assign press_ok   = !level && st_reg.last_level && (d_rel > debounce);
    assign release_ok = level && !st_reg.last_level && (d_prs > debounce)
                        && !st_reg.double_done;

    always_comb begin
        st_next      = st_reg;
        res          = '0;
        second_press = 1'b0;
        d_rel_new    = d_rel;
        d_prs_new    = d_prs;

        if (press_ok) begin
            st_next.press_time        = now;
            d_prs_new                 = '0;
            st_next.skip_release      = 1'b0;
            st_next.single_allowed    = 1'b1;
            st_next.hold_done         = 1'b0;
            st_next.long_hold_done    = 1'b0;
            st_next.holding_flag      = 1'b0;
            st_next.holding_long_flag = 1'b0;
            if (d_rel > gap_x2) begin
                st_next.double_done = 1'b0;
            end
            second_press = (d_rel < gap) && !st_reg.double_on_release
                           && st_reg.awaiting_second && !st_next.double_done;
            st_next.double_on_release = second_press;
            res.press_event           = !second_press;
            st_next.awaiting_second   = 1'b0;
        end else if (release_ok) begin
            res.release_event         = 1'b1;
            st_next.holding_flag      = 1'b0;
            st_next.holding_long_flag = 1'b0;
            if (!st_reg.skip_release) begin
                st_next.release_time = now;
                d_rel_new            = '0;
                if (!st_reg.double_on_release) begin
                    st_next.awaiting_second = 1'b1;
                end else begin
                    res.double_click_event    = 1'b1;
                    st_next.double_done       = 1'b1;
                    st_next.double_on_release = 1'b0;
                    st_next.awaiting_second   = 1'b0;
                    st_next.single_allowed    = 1'b0;
                end
            end
        end

        // single click once the gap has run out with no second press
        if (level && (d_rel_new >= gap) && st_next.awaiting_second
            && !st_next.double_on_release && st_next.single_allowed) begin
            res.click_event         = 1'b1;
            st_next.awaiting_second = 1'b0;
        end

        if (!level && (d_prs_new >= bchc_pkg::TIME_W'(cfg.hold_ms))) begin
            if (!st_next.hold_done) begin
                res.hold_event            = 1'b1;
                st_next.holding_flag      = 1'b1;
                st_next.skip_release      = 1'b1;
                st_next.double_on_release = 1'b0;
                st_next.awaiting_second   = 1'b0;
                st_next.hold_done         = 1'b1;
            end
            if ((d_prs_new >= bchc_pkg::TIME_W'(cfg.long_hold_ms))
                && !st_next.long_hold_done) begin
                res.long_hold_event       = 1'b1;
                st_next.holding_long_flag = 1'b1;
                st_next.long_hold_done    = 1'b1;
            end
        end

        res.is_down         = !level && (d_rel_new > debounce);
        res.is_holding      = st_next.holding_flag;
        res.is_holding_long = st_next.holding_long_flag;
        st_next.last_level  = level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= bchc_pkg::ST_RST;
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== rtl/core/button_click_hold_classifier.sv =====
// ----------------------------------------------------------------------------
// button_click_hold_classifier
// Debounced press/release, click, double-click and hold classifier.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one button sample per transfer, the raw active-low level and
//   a free-running millisecond timestamp (wraps modulo 2^32).
//   m_* channel: exactly one result transfer per sample, carrying the one-shot
//   event flags and the level flags (is_down, is_holding, is_holding_long).
//   cfg_* port: four 16-bit thresholds (debounce, double-click gap, hold,
//   long hold), written with cfg_wr_en; write only while the block is idle.
// Path: an input transfer is captured in the input register; the classify step
//   then writes its result into the output register, which drives m_tvalid.
// Throughput: one sample per cycle while m_tready is high. The classify step
//   reads and updates the button state together, so samples follow back to back.
// Stalls: when m_tready is low the result is held in the output register; the
//   input register takes at most one more sample, then s_tready drops until the
//   result drains. No sample or result is lost or duplicated.
// Reset (aresetn low, synchronous): thresholds return to 20/250/1000/3000 ms,
//   button state to released with all flags clear, both stages empty.
// ----------------------------------------------------------------------------
module button_click_hold_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] button_level, [32:1] time_now_ms, [39:33] zero
    input  logic [bchc_pkg::S_DATA_W-1:0]   s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] press_event, [1] release_event, [2] click_event,
    // [3] double_click_event, [4] hold_event, [5] long_hold_event,
    // [6] is_down, [7] is_holding, [8] is_holding_long, [15:9] zero
    output logic [bchc_pkg::M_DATA_W-1:0]   m_tdata,

    input  logic                            cfg_wr_en,
    input  logic [bchc_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [bchc_pkg::CFG_W-1:0]      cfg_wdata
);

    // input stage
    logic                        in_valid_reg;
    logic                        in_level_reg;
    logic [bchc_pkg::TIME_W-1:0] in_time_reg;

    // output stage
    logic                        out_valid_reg;
    bchc_pkg::res_t              out_res_reg;

    bchc_pkg::cfg_t cfg;
    bchc_pkg::res_t res;
    logic           advance;

    // the classify step fires when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_level_reg <= s_tdata[0];
            in_time_reg  <= s_tdata[bchc_pkg::TIME_W:1];
        end
    end

    bchc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bchc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .level   (in_level_reg),
        .now     (in_time_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bchc_pkg::M_DATA_W'(out_res_reg);

endmodule
